[hdl/rau_pkg.sv]
`default_nettype none
package rau_pkg;
    localparam logic [2:0] FN_ADD = 3'd0;
    localparam logic [2:0] FN_SUB = 3'd1;
    localparam logic [2:0] FN_MUL = 3'd2;
    localparam logic [2:0] FN_DIV = 3'd3;
    localparam logic [2:0] FN_GT  = 3'd4;
    localparam logic [2:0] FN_LT  = 3'd5;
    localparam logic [2:0] FN_EQ  = 3'd6;
    localparam logic [2:0] FN_NOP = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic form;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic early;
        logic gcd_done;
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

[hdl/rau_ctrl.sv]
`default_nettype none
module rau_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire rau_pkg::t_stat i_stat,
    input  wire logic          i_out_ready,
    output rau_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_valid
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MULA = 3'd1;
    localparam logic [2:0] S_MULB = 3'd2;
    localparam logic [2:0] S_FORM = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] r_state, n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MULA;
                end
            end
            S_MULA: begin
                o_cmd.mul_a = 1'b1;
                n_state = S_MULB;
            end
            S_MULB: begin
                o_cmd.mul_b = 1'b1;
                n_state = S_FORM;
            end
            S_FORM: begin
                o_cmd.form = 1'b1;
                n_state = S_GCD;
            end
            S_GCD: begin
                if (i_stat.early) begin
                    n_state = S_OUT;
                end else if (i_stat.gcd_done) begin
                    o_cmd.div_init = 1'b1;
                    n_state = S_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_FIN;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);
endmodule
`default_nettype wire

[hdl/rau_dp.sv]
`default_nettype none
module rau_dp #(
    parameter int WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire rau_pkg::t_cmd i_cmd,
    input  wire logic [2:0]    i_func,
    input  wire logic [31:0]   i_a_num,
    input  wire logic [30:0]   i_a_den,
    input  wire logic [31:0]   i_b_num,
    input  wire logic [30:0]   i_b_den,
    output rau_pkg::t_stat     o_stat,
    output logic [31:0]        o_res_num,
    output logic [30:0]        o_res_den,
    output logic               o_cmp_flag,
    output logic [1:0]         o_status
);
    logic [2:0]  r_func;
    logic signed [32:0] r_an, r_bn;
    logic signed [32:0] r_ad, r_bd;
    logic signed [63:0] r_p1, r_p2, r_pd;
    logic [64:0] r_mn, r_md;
    logic        r_neg, r_early;
    // binary gcd
    logic [64:0] r_gx, r_gy;
    logic [6:0]  r_sh;
    // restoring division of both parts by the gcd
    logic [64:0] r_g, r_qn, r_qd, r_rn, r_rd;
    logic [6:0]  r_cnt;
    logic [31:0] r_res_num;
    logic [30:0] r_res_den;
    logic        r_cmp;
    logic [1:0]  r_status;

    localparam logic [64:0] LIM = 65'd1 << (WIDTH - 1);

    logic signed [65:0] w_n;
    logic signed [64:0] w_d;
    logic [64:0] w_rn, w_rd;
    logic signed [64:0] w_dif;
    logic [64:0] w_gmin, w_gabs;

    assign w_rn = {r_rn[63:0], r_qn[64]};
    assign w_rd = {r_rd[63:0], r_qd[64]};
    assign w_gmin = (r_gx < r_gy) ? r_gx : r_gy;
    assign w_gabs = (r_gx < r_gy) ? (r_gy - r_gx) : (r_gx - r_gy);
    assign w_dif = {r_p1[63], r_p1} - {r_p2[63], r_p2};

    // form the numerator: cross sum for add, cross difference for sub, else the first product
    always_comb begin
        unique case (r_func)
            rau_pkg::FN_ADD: w_n = 66'(r_p1) + 66'(r_p2);
            rau_pkg::FN_SUB: w_n = 66'(r_p1) - 66'(r_p2);
            default:         w_n = 66'(r_p1);
        endcase
        w_d = 65'(r_pd);
    end

    always_ff @(posedge i_clk) begin
        // capture operands
        if (i_cmd.load) begin
            r_func <= i_func;
            r_an <= 33'(signed'(i_a_num));
            r_bn <= 33'(signed'(i_b_num));
            r_ad <= {2'b0, i_a_den};
            r_bd <= {2'b0, i_b_den};
            r_early <= 1'b0;
        end
        // first products
        if (i_cmd.mul_a) begin
            r_p1 <= 64'(r_an * r_bd);
            if (r_func == rau_pkg::FN_MUL) r_p2 <= 64'(r_an * r_bn);
            else r_p2 <= 64'(r_bn * r_ad);
        end
        // second products and special cases
        if (i_cmd.mul_b) begin
            if (r_func == rau_pkg::FN_MUL) r_p1 <= r_p2;
            if (r_func == rau_pkg::FN_DIV) r_pd <= 64'(r_ad * r_bn);
            else r_pd <= 64'(r_ad * r_bd);
        end
        if (i_cmd.form) begin
            r_neg <= w_n[65] ^ w_d[64];
            r_mn <= w_n[65] ? 65'(-w_n) : 65'(w_n);
            r_md <= w_d[64] ? 65'(-w_d) : 65'(w_d);
            r_gx <= w_n[65] ? 65'(-w_n) : 65'(w_n);
            r_gy <= w_d[64] ? 65'(-w_d) : 65'(w_d);
            r_sh <= '0;
            r_early <= 1'b1;
            r_res_num <= '0;
            r_res_den <= '0;
            r_cmp <= 1'b0;
            r_status <= rau_pkg::ST_OK;
            if (r_func == rau_pkg::FN_NOP) begin
                r_status <= rau_pkg::ST_OK;
            end else if (r_ad == 0 || r_bd == 0) begin
                r_status <= rau_pkg::ST_DIVZ;
            end else if (r_func == rau_pkg::FN_GT) begin
                r_cmp <= !w_dif[64] && (w_dif != 0);
            end else if (r_func == rau_pkg::FN_LT) begin
                r_cmp <= w_dif[64];
            end else if (r_func == rau_pkg::FN_EQ) begin
                r_cmp <= (w_dif == 0);
            end else if (r_func == rau_pkg::FN_DIV && r_bn == 0) begin
                r_status <= rau_pkg::ST_DIVZ;
            end else if (w_n == 0) begin
                r_res_den <= 31'd1;
            end else begin
                r_early <= 1'b0;
            end
        end
        // one binary gcd step
        if (i_cmd.gcd_step) begin
            if (!r_gx[0] && !r_gy[0]) begin
                r_gx <= r_gx >> 1;
                r_gy <= r_gy >> 1;
                r_sh <= r_sh + 7'd1;
            end else if (!r_gx[0]) begin
                r_gx <= r_gx >> 1;
            end else if (!r_gy[0]) begin
                r_gy <= r_gy >> 1;
            end else begin
                r_gx <= w_gmin;
                r_gy <= w_gabs;
            end
        end
        if (i_cmd.div_init) begin
            r_g <= r_gx << r_sh;
            r_qn <= r_mn;
            r_qd <= r_md;
            r_rn <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end
        // one quotient bit for both parts
        if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 7'd1;
            if (w_rn >= r_g) begin
                r_rn <= w_rn - r_g;
                r_qn <= {r_qn[63:0], 1'b1};
            end else begin
                r_rn <= w_rn;
                r_qn <= {r_qn[63:0], 1'b0};
            end
            if (w_rd >= r_g) begin
                r_rd <= w_rd - r_g;
                r_qd <= {r_qd[63:0], 1'b1};
            end else begin
                r_rd <= w_rd;
                r_qd <= {r_qd[63:0], 1'b0};
            end
        end
        // range check and sign
        if (i_cmd.finish) begin
            if (r_qd > LIM - 65'd1 || (r_neg ? (r_qn > LIM) : (r_qn > LIM - 65'd1))) begin
                r_status <= rau_pkg::ST_OVF;
            end else begin
                r_res_num <= r_neg ? 32'(-r_qn) : r_qn[31:0];
                r_res_den <= r_qd[30:0];
            end
        end
    end

    assign o_stat.early    = r_early;
    assign o_stat.gcd_done = (r_gy == 0);
    assign o_stat.div_done = (r_cnt == 7'd65);
    assign o_res_num  = r_res_num;
    assign o_res_den  = r_res_den;
    assign o_cmp_flag = r_cmp;
    assign o_status   = r_status;
endmodule
`default_nettype wire

[hdl/rational_arithmetic_unit.sv]
// rational arithmetic unit
// input beat on s_axis: tuser = func, tdata = a_num, a_den, b_num, b_den (128 bits)
// output beat on m_axis: tdata = res_num, res_den, cmp_flag, status (72 bits)
// one item at a time: s_axis_tready is high only while the unit is idle,
// so the next beat is taken the cycle after the result beat leaves
// steps: load, first products, second products and form; comparisons,
// errors, zero results and func 7 then go straight to output; otherwise
// the binary gcd loop, the divider load, the shared divider steps (one
// quotient bit of each 65-bit part per step) and a range check
// the result register holds its beat while m_axis_tready is low and no
// new item is taken until that beat leaves
// synchronous active-low reset returns the controller to idle, no output
// divide by zero fraction or zero denominator gives status 1; a reduced
// result out of range gives status 2; unused func 7 gives all zeros
`default_nettype none
module rational_arithmetic_unit #(
    parameter int WIDTH = 32
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  wire logic [2:0]   s_axis_tuser,  // func
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [71:0]       m_axis_tdata   // res_num, res_den, cmp_flag, status
);
    rau_pkg::t_cmd  w_cmd;
    rau_pkg::t_stat w_stat;
    logic w_busy;
    logic [31:0] w_rn;
    logic [30:0] w_rd;
    logic w_cf;
    logic [1:0] w_st;

    // controller
    rau_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start(s_axis_tvalid), .i_stat(w_stat),
        .i_out_ready(m_axis_tready),
        .o_cmd(w_cmd), .o_busy(w_busy), .o_valid(m_axis_tvalid)
    );

    // datapath
    rau_dp #(.WIDTH(WIDTH)) u_dp (
        .i_clk(i_clk), .i_cmd(w_cmd), .i_func(s_axis_tuser),
        .i_a_num(s_axis_tdata[31:0]), .i_a_den(s_axis_tdata[62:32]),
        .i_b_num(s_axis_tdata[94:63]), .i_b_den(s_axis_tdata[125:95]),
        .o_stat(w_stat), .o_res_num(w_rn), .o_res_den(w_rd),
        .o_cmp_flag(w_cf), .o_status(w_st)
    );

    assign s_axis_tready = !w_busy;
    assign m_axis_tdata = {6'd0, w_st, w_cf, w_rd, w_rn};

`ifndef NO_ASSERTIONS
    // no input taken while a result waits
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken while busy");
    // status code is never the unused value
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_st != 2'd3)) else $error("bad status");
    // comparison flag only with ok status
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && w_cf) |-> (w_st == rau_pkg::ST_OK && w_rd == '0))
        else $error("flag with result");
`endif
endmodule
`default_nettype wire
